// ===== rtl/crc8fr_pkg.sv =====
// Package for the CRC-8 checked frame receiver.
// Holds frame marker constants, result kinds and the CRC-8 byte update.
// No dependencies.
package crc8fr_pkg;

  localparam logic [7:0] FRAME_START1 = 8'h23;
  localparam logic [7:0] FRAME_START2 = 8'h21;
  localparam logic [7:0] FRAME_END1 = 8'h2A;
  localparam logic [7:0] FRAME_END2 = 8'h26;
  localparam logic [7:0] CRC_POLY = 8'h07;
  localparam logic [7:0] MAX_COUNT_RESET = 8'd250;

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_GOOD = 2'd1,
    KIND_BAD_CRC = 2'd2,
    KIND_ABORT = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t out_kind;
    logic [7:0] out_byte;
  } result_t;

  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ===== rtl/crc8fr_if.sv =====
// Valid/ready channel interfaces for the frame receiver.
// Depends on crc8fr_pkg for the result kind type.
interface crc8fr_in_if;
  logic valid;
  logic ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface crc8fr_out_if;
  import crc8fr_pkg::*;
  logic valid;
  logic ready;
  kind_t out_kind;
  logic [7:0] out_byte;

  modport source (output valid, output out_kind, output out_byte, input ready);
  modport sink (input valid, input out_kind, input out_byte, output ready);
endinterface

// ===== rtl/crc8_checked_frame_receiver_core.sv =====
// Frame receiver: hunts for '#','!',len16,payload,'*',crc,'&' and checks CRC-8.
// The result is registered; one byte per cycle is taken while the skid entry is empty.
// A two-entry output stage (result register plus skid) absorbs one result under stall; input stalls while skid is full.
// Reset (rst_n low, synchronous) returns to hunting, clears results, limit to 250.
// Depends on crc8fr_pkg and crc8fr_if.
module crc8_checked_frame_receiver_core (
  input  logic                clk,
  input  logic                rst_n,
  crc8fr_in_if.sink           in_rx,
  crc8fr_out_if.source        out_res,
  input  logic                cfg_wr_en,
  input  logic [7:0]          cfg_wr_data
);
  import crc8fr_pkg::*;

  typedef enum logic [2:0] {
    PH_HUNT   = 3'd0,
    PH_START2 = 3'd1,
    PH_LEN_HI = 3'd2,
    PH_LEN_LO = 3'd3,
    PH_BODY   = 3'd4
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [15:0] frame_length_r, frame_length_nxt;
  logic [8:0]  byte_count_r, byte_count_nxt;
  logic [7:0]  running_crc_r, running_crc_nxt;
  logic [7:0]  received_crc_r, received_crc_nxt;
  logic [7:0]  max_count_r;

  logic        out_valid_r, skid_valid_r;
  result_t     out_data_r, skid_data_r;

  logic        accept, pop, res_valid;
  result_t     res;
  logic [8:0]  count_inc;
  logic [16:0] count_ext, len_ext;
  logic [7:0]  b;

  assign in_rx.ready = !skid_valid_r;
  assign accept = in_rx.valid && in_rx.ready;
  assign pop = out_valid_r && out_res.ready;
  assign out_res.valid = out_valid_r;
  assign out_res.out_kind = out_data_r.out_kind;
  assign out_res.out_byte = out_data_r.out_byte;

  assign b = in_rx.rx_byte;
  assign count_inc = byte_count_r + 9'd1;
  assign count_ext = {8'd0, count_inc};
  assign len_ext = {1'b0, frame_length_r};

  always_comb begin
    phase_nxt = phase_r;
    frame_length_nxt = frame_length_r;
    byte_count_nxt = byte_count_r;
    running_crc_nxt = running_crc_r;
    received_crc_nxt = received_crc_r;
    res_valid = 1'b0;
    res.out_kind = KIND_PAYLOAD;
    res.out_byte = 8'd0;
    case (phase_r)
      PH_START2: begin
        phase_nxt = (b == FRAME_START2) ? PH_LEN_HI : PH_HUNT;
      end
      PH_LEN_HI: begin
        frame_length_nxt = {b, 8'd0};
        phase_nxt = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        frame_length_nxt = {frame_length_r[15:8], b};
        phase_nxt = PH_BODY;
      end
      PH_BODY: begin
        byte_count_nxt = count_inc;
        if (count_inc > {1'b0, max_count_r}) begin
          res_valid = 1'b1;
          res.out_kind = KIND_ABORT;
          phase_nxt = PH_HUNT;
        end else if (count_ext <= len_ext) begin
          running_crc_nxt = crc8_update(running_crc_r, b);
          res_valid = 1'b1;
          res.out_byte = b;
        end else if (count_ext == len_ext + 17'd1) begin
          if (b != FRAME_END1) begin
            res_valid = 1'b1;
            res.out_kind = KIND_ABORT;
            phase_nxt = PH_HUNT;
          end
        end else if (count_ext == len_ext + 17'd2) begin
          received_crc_nxt = b;
        end else if (count_ext == len_ext + 17'd3) begin
          res_valid = 1'b1;
          phase_nxt = PH_HUNT;
          if (b != FRAME_END2) begin
            res.out_kind = KIND_ABORT;
          end else if (received_crc_r == ~running_crc_r) begin
            res.out_kind = KIND_GOOD;
          end else begin
            res.out_kind = KIND_BAD_CRC;
          end
        end
      end
      default: begin
        phase_nxt = (b == FRAME_START1) ? PH_START2 : PH_HUNT;
      end
    endcase
    if (phase_r == PH_BODY && phase_nxt == PH_HUNT) begin
      frame_length_nxt = 16'd0;
      byte_count_nxt = 9'd0;
      running_crc_nxt = 8'd0;
      received_crc_nxt = 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
      frame_length_r <= 16'd0;
      byte_count_r <= 9'd0;
      running_crc_r <= 8'd0;
      received_crc_r <= 8'd0;
      max_count_r <= MAX_COUNT_RESET;
      out_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        max_count_r <= cfg_wr_data;
      end
      if (accept) begin
        phase_r <= phase_nxt;
        frame_length_r <= frame_length_nxt;
        byte_count_r <= byte_count_nxt;
        running_crc_r <= running_crc_nxt;
        received_crc_r <= received_crc_nxt;
      end
      if (skid_valid_r) begin
        if (pop) begin
          out_data_r <= skid_data_r;
          skid_valid_r <= 1'b0;
        end
      end else if (accept && res_valid) begin
        if (!out_valid_r || pop) begin
          out_data_r <= res;
          out_valid_r <= 1'b1;
        end else begin
          skid_data_r <= res;
          skid_valid_r <= 1'b1;
        end
      end else if (pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/crc8fr_checker.sv =====
// Port-level checker for the frame receiver, bound to the receiver core.
// Depends on crc8fr_pkg for result kind codes.
module crc8fr_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] out_kind,
  input logic [7:0] out_byte
);
  import crc8fr_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) && $stable(out_byte))
    else $error("result changed under stall");

  a_verdict_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != KIND_PAYLOAD |-> out_byte == 8'd0)
    else $error("verdict carries nonzero byte");

  a_backpressure_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input stalled with empty output");

  a_reset_empties: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("output not empty after reset");

  a_accept_while_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |=> in_ready)
    else $error("input stalled after empty output");

endmodule

bind crc8_checked_frame_receiver_core crc8fr_checker u_crc8fr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_rx.valid),
  .in_ready  (in_rx.ready),
  .out_valid (out_res.valid),
  .out_ready (out_res.ready),
  .out_kind  (out_res.out_kind),
  .out_byte  (out_res.out_byte)
);
